@@ src/midi_running_status_parser_defines.svh @@
// ----------------------------------------------------------------------------
// midi_running_status_parser_defines
// Assertion macros shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH
`define MIDI_RUNNING_STATUS_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define MRSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define MRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrsp_pkg
// Widths, byte ranges and byte classification for the MIDI parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrsp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned DataW = 7;

  // Byte range boundaries of the MIDI stream.
  localparam logic [ByteW-1:0] RtFirst  = 8'hF8;
  localparam logic [ByteW-1:0] SysFirst = 8'hF0;
  localparam logic [ByteW-1:0] StatusBit = 8'h80;

  // Upper nibbles of channel messages that carry a single data byte.
  localparam logic [3:0] KindProgram  = 4'hC;
  localparam logic [3:0] KindPressure = 4'hD;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_STATUS,
    CLS_SYSTEM,
    CLS_REALTIME
  } byte_class_e;

  // Sort one received byte into its class.
  function automatic byte_class_e classify(input logic [ByteW-1:0] b);
    byte_class_e cls;
    if (b >= RtFirst) begin
      cls = CLS_REALTIME;
    end else if (b >= SysFirst) begin
      cls = CLS_SYSTEM;
    end else if ((b & StatusBit) != '0) begin
      cls = CLS_STATUS;
    end else begin
      cls = CLS_DATA;
    end
    return cls;
  endfunction

  // A channel status takes two data bytes unless it is program change or
  // channel pressure.
  function automatic logic takes_two(input logic [ByteW-1:0] b);
    return !((b[7:4] == KindProgram) || (b[7:4] == KindPressure));
  endfunction

endpackage

@@ src/mrsp_in_if.sv @@
// ----------------------------------------------------------------------------
// mrsp_in_if
// Valid/ready channel that carries one received MIDI byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrsp_in_if import mrsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/mrsp_out_if.sv @@
// ----------------------------------------------------------------------------
// mrsp_out_if
// Valid/ready channel that carries one parsed message per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrsp_out_if import mrsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_realtime;
  logic [ByteW-1:0] status_out;
  logic [DataW-1:0] first_data;
  logic [DataW-1:0] second_data;

  modport source (output valid, output is_realtime, output status_out,
                  output first_data, output second_data, input ready);
  modport sink   (input valid, input is_realtime, input status_out,
                  input first_data, input second_data, output ready);
endinterface

@@ src/midi_running_status_parser.sv @@
// Results: the byte that completes a message passes the input register, then
// the result register, from which the result is offered to the receiver.
// Throughput: one byte per cycle while no result waits on a stalled output;
// the result register is refilled in the same cycle its contents are taken.
// Reset: rst_ni clears running status, held data and both valid flags.
// ----------------------------------------------------------------------------
// midi_running_status_parser
// MIDI byte stream parser with running status and real-time pass-through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_running_status_parser_defines.svh"

module midi_running_status_parser import mrsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrsp_in_if.sink   rx_i,
  mrsp_out_if.source msg_o
);

  // Input register.
  logic             byte_vld_q;
  logic [ByteW-1:0] byte_q;

  // Parser state.
  logic [ByteW-1:0] run_status_q, run_status_d;
  logic [DataW-1:0] held_data_q, held_data_d;
  logic             bytes_held_q, bytes_held_d;
  logic             wants_two_q, wants_two_d;

  // Result register.
  logic             out_vld_q;
  logic             out_rt_q, out_rt_d;
  logic [ByteW-1:0] out_status_q, out_status_d;
  logic [DataW-1:0] out_d1_q, out_d1_d;
  logic [DataW-1:0] out_d2_q, out_d2_d;

  byte_class_e      cls;
  logic             has_result;
  logic             out_free;
  logic             adv;
  logic             in_xfer;

  assign cls      = classify(byte_q);
  assign out_free = !out_vld_q || msg_o.ready;
  assign adv      = byte_vld_q && (!has_result || out_free);
  assign in_xfer  = rx_i.valid && rx_i.ready;

  assign rx_i.ready = !byte_vld_q || adv;

  // Decode the registered byte against the current state.
  always_comb begin
    run_status_d = run_status_q;
    held_data_d  = held_data_q;
    bytes_held_d = bytes_held_q;
    wants_two_d  = wants_two_q;
    has_result   = 1'b0;
    out_rt_d     = 1'b0;
    out_status_d = run_status_q;
    out_d1_d     = byte_q[DataW-1:0];
    out_d2_d     = '0;
    unique case (cls)
      CLS_REALTIME: begin
        has_result   = 1'b1;
        out_rt_d     = 1'b1;
        out_status_d = byte_q;
        out_d1_d     = '0;
      end
      CLS_SYSTEM: begin
        run_status_d = '0;
        bytes_held_d = 1'b0;
      end
      CLS_STATUS: begin
        run_status_d = byte_q;
        bytes_held_d = 1'b0;
        wants_two_d  = takes_two(byte_q);
      end
      CLS_DATA: begin
        // Stray data with no armed status is dropped.
        if (run_status_q != '0) begin
          if (!wants_two_q) begin
            has_result = 1'b1;
          end else if (!bytes_held_q) begin
            held_data_d  = byte_q[DataW-1:0];
            bytes_held_d = 1'b1;
          end else begin
            has_result   = 1'b1;
            bytes_held_d = 1'b0;
            out_d1_d     = held_data_q;
            out_d2_d     = byte_q[DataW-1:0];
          end
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // Input register: loads on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      byte_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  // Parser state advances when the registered byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status_q <= '0;
      held_data_q  <= '0;
      bytes_held_q <= 1'b0;
      wants_two_q  <= 1'b0;
    end else if (adv) begin
      run_status_q <= run_status_d;
      held_data_q  <= held_data_d;
      bytes_held_q <= bytes_held_d;
      wants_two_q  <= wants_two_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && has_result) begin
      out_vld_q <= 1'b1;
    end else if (msg_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (adv && has_result) begin
      out_rt_q     <= out_rt_d;
      out_status_q <= out_status_d;
      out_d1_q     <= out_d1_d;
      out_d2_q     <= out_d2_d;
    end
  end

  assign msg_o.valid       = out_vld_q;
  assign msg_o.is_realtime = out_rt_q;
  assign msg_o.status_out  = out_status_q;
  assign msg_o.first_data  = out_d1_q;
  assign msg_o.second_data = out_d2_q;

  // A held data byte only exists for an armed two-byte status.
  `MRSP_ASSERT_IMPL(a_held_needs_status, clk_i, rst_ni, bytes_held_q,
      (run_status_q != '0) && wants_two_q, "held data byte without two-byte status")

  // A channel message always carries a channel status byte.
  `MRSP_ASSERT_IMPL(a_chan_status, clk_i, rst_ni, out_vld_q && !out_rt_q,
      out_status_q[7] && (out_status_q < SysFirst), "channel result with bad status")

  // Real-time bytes leave the parser state untouched.
  `MRSP_ASSERT_NEXT(a_rt_keeps_state, clk_i, rst_ni, adv && (cls == CLS_REALTIME),
      $stable(run_status_q) && $stable(bytes_held_q), "real-time byte changed state")

  // A byte that cannot advance stays in the input register.
  `MRSP_ASSERT_NEXT(a_byte_holds, clk_i, rst_ni, byte_vld_q && !adv,
      byte_vld_q && $stable(byte_q), "stalled input byte lost")

endmodule

@@ test/midi_running_status_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_running_status_parser_tb
// Feeds MIDI byte streams into the parser and checks every parsed message.
// A short table of directed bytes comes first. It covers real-time bytes,
// system bytes, running status, one- and two-byte messages and stray data.
// Random streams with random content follow, mostly well formed. An internal
// model of the parser predicts each message, and the predictions are
// compared in order with what leaves the output channel. Both channels idle
// at random.
// ----------------------------------------------------------------------------

module midi_running_status_parser_tb;
  import mrsp_pkg::*;

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned RstCycles  = 12;
  localparam int unsigned RandBytes  = 750;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumRows    = 26;

  // One parsed message as it appears on the output channel.
  typedef struct packed {
    logic             is_rt;
    logic [ByteW-1:0] status;
    logic [DataW-1:0] d1;
    logic [DataW-1:0] d2;
  } midi_msg_t;

  // Directed rows either take their result from the parser model or give it.
  typedef enum bit {
    ROW_MODEL,
    ROW_TYPED
  } row_mode_e;

  typedef struct {
    logic [ByteW-1:0] rx;
    row_mode_e        mode;
    bit               has_msg;
    midi_msg_t        msg;
  } stim_row_t;

  localparam midi_msg_t NoMsg = '0;

  logic clk;
  logic rst_n;

  mrsp_in_if  rx_if ();
  mrsp_out_if msg_if ();

  midi_running_status_parser DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_if),
    .msg_o (msg_if)
  );

  // Parser model state.
  logic [ByteW-1:0] armed_status;
  logic [DataW-1:0] held_byte;
  bit               data_pending;
  bit               two_bytes;

  midi_msg_t   expected_msgs [$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  logic [31:0] stall_pat;
  int unsigned stall_age;

  // Directed stream: expected results are typed where they are obvious.
  stim_row_t directed_rows [NumRows] = '{
    '{8'h40, ROW_TYPED, 1'b0, NoMsg},                             // stray data
    '{8'hF8, ROW_TYPED, 1'b1, '{1'b1, 8'hF8, 7'h00, 7'h00}},
    '{8'hFF, ROW_TYPED, 1'b1, '{1'b1, 8'hFF, 7'h00, 7'h00}},
    '{8'h90, ROW_TYPED, 1'b0, NoMsg},
    '{8'h00, ROW_TYPED, 1'b0, NoMsg},
    '{8'h7F, ROW_TYPED, 1'b1, '{1'b0, 8'h90, 7'h00, 7'h7F}},
    '{8'h7F, ROW_TYPED, 1'b0, NoMsg},                             // running
    '{8'hFA, ROW_TYPED, 1'b1, '{1'b1, 8'hFA, 7'h00, 7'h00}},      // mid-message
    '{8'h00, ROW_TYPED, 1'b1, '{1'b0, 8'h90, 7'h7F, 7'h00}},
    '{8'h80, ROW_MODEL, 1'b0, NoMsg},
    '{8'h12, ROW_MODEL, 1'b0, NoMsg},
    '{8'hEF, ROW_MODEL, 1'b0, NoMsg},                             // drops 0x12
    '{8'h01, ROW_MODEL, 1'b0, NoMsg},
    '{8'h02, ROW_MODEL, 1'b0, NoMsg},
    '{8'hC5, ROW_MODEL, 1'b0, NoMsg},
    '{8'h7F, ROW_TYPED, 1'b1, '{1'b0, 8'hC5, 7'h7F, 7'h00}},
    '{8'h00, ROW_TYPED, 1'b1, '{1'b0, 8'hC5, 7'h00, 7'h00}},
    '{8'hD0, ROW_MODEL, 1'b0, NoMsg},
    '{8'h55, ROW_MODEL, 1'b0, NoMsg},
    '{8'hB3, ROW_MODEL, 1'b0, NoMsg},
    '{8'h10, ROW_MODEL, 1'b0, NoMsg},
    '{8'hF0, ROW_TYPED, 1'b0, NoMsg},                             // sysex start
    '{8'h20, ROW_TYPED, 1'b0, NoMsg},
    '{8'hF7, ROW_TYPED, 1'b0, NoMsg},
    '{8'hA0, ROW_MODEL, 1'b0, NoMsg},
    '{8'h6A, ROW_MODEL, 1'b0, NoMsg}
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // Advance the parser model by one byte. Returns 1 when a message results.
  function automatic bit parse_midi_byte(input logic [ByteW-1:0] b,
                                         output midi_msg_t m);
    byte_class_e cls;
    bit          got;
    m   = NoMsg;
    got = 1'b0;
    if (b >= RtFirst) begin
      cls = CLS_REALTIME;
    end else if (b >= SysFirst) begin
      cls = CLS_SYSTEM;
    end else if (b[7]) begin
      cls = CLS_STATUS;
    end else begin
      cls = CLS_DATA;
    end
    case (cls)
      CLS_REALTIME: begin
        m.is_rt  = 1'b1;
        m.status = b;
        got      = 1'b1;
      end
      CLS_SYSTEM: begin
        armed_status = '0;
        data_pending = 1'b0;
      end
      CLS_STATUS: begin
        armed_status = b;
        data_pending = 1'b0;
        two_bytes    = !((b[7:4] == KindProgram) || (b[7:4] == KindPressure));
      end
      default: begin
        // Data with no armed status is dropped silently.
        if (armed_status != '0) begin
          if (!two_bytes) begin
            m.status = armed_status;
            m.d1     = b[DataW-1:0];
            got      = 1'b1;
          end else if (!data_pending) begin
            held_byte    = b[DataW-1:0];
            data_pending = 1'b1;
          end else begin
            data_pending = 1'b0;
            m.status     = armed_status;
            m.d1         = held_byte;
            m.d2         = b[DataW-1:0];
            got          = 1'b1;
          end
        end
      end
    endcase
    return got;
  endfunction

  // Random byte, weighted toward channel messages with running status.
  function automatic logic [ByteW-1:0] random_midi_byte();
    int unsigned pick;
    logic [ByteW-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      b = ByteW'($urandom_range(32'hF8, 32'hFF));
    end else if (pick < 10) begin
      b = ByteW'($urandom_range(32'hF0, 32'hF7));
    end else if (pick < 24) begin
      b = ByteW'($urandom_range(32'h80, 32'hEF));
    end else begin
      b = ByteW'($urandom_range(32'h00, 32'h7F));
    end
    return b;
  endfunction

  // Present one byte at the falling edge and hold it until its transfer.
  // Gaps fall only at the start of a burst, so valid stays high within one.
  task automatic send_midi_byte(input logic [ByteW-1:0] b, output bit accepted);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(24, 64)
                                               : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    accepted = 1'b1;
    @(negedge clk);
  endtask

  // Receiver stalls follow a rotating pattern that is replaced when stall_age wraps.
  initial begin
    msg_if.ready = 1'b0;
    stall_pat    = '1;
    stall_age    = 0;
    forever begin
      @(negedge clk);
      msg_if.ready <= stall_pat[0];
      stall_pat    = {stall_pat[0], stall_pat[31:1]};
      stall_age++;
      if (stall_age == 64) begin
        stall_age = 0;
        stall_pat = ($urandom_range(0, 3) == 0) ? '1 : ($urandom() | 32'h1);
      end
    end
  end

  // Compare every output transfer with the oldest expected message.
  always @(posedge clk) begin
    midi_msg_t got_msg;
    midi_msg_t exp_msg;
    if (rst_n && msg_if.valid && msg_if.ready) begin
      got_msg = '{msg_if.is_realtime, msg_if.status_out,
                  msg_if.first_data, msg_if.second_data};
      if (expected_msgs.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("[%0t] unexpected message rt=%0b st=%02h d1=%02h d2=%02h",
                   $realtime, got_msg.is_rt, got_msg.status, got_msg.d1,
                   got_msg.d2);
        end
      end else begin
        exp_msg = expected_msgs.pop_front();
        if (got_msg !== exp_msg) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $write("[%0t] mismatch: exp rt=%0b st=%02h d1=%02h d2=%02h",
                   $realtime, exp_msg.is_rt, exp_msg.status, exp_msg.d1,
                   exp_msg.d2);
            $display(", got rt=%0b st=%02h d1=%02h d2=%02h",
                     got_msg.is_rt, got_msg.status, got_msg.d1, got_msg.d2);
          end
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL midi_running_status_parser");
    $finish;
  end

  // Main stimulus.
  initial begin
    midi_msg_t        model_msg;
    bit               model_got;
    bit               accepted;
    int unsigned      live_bytes;
    logic [ByteW-1:0] b;

    rst_n         = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    armed_status  = '0;
    held_byte     = '0;
    data_pending  = 1'b0;
    two_bytes     = 1'b0;
    mismatches    = 0;
    burst_left    = 0;
    live_bytes    = 0;

    repeat (RstCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (directed_rows[i]) begin
      send_midi_byte(directed_rows[i].rx, accepted);
      model_got = parse_midi_byte(directed_rows[i].rx, model_msg);
      if (directed_rows[i].mode == ROW_TYPED) begin
        if (directed_rows[i].has_msg) expected_msgs.push_back(directed_rows[i].msg);
      end else if (model_got) begin
        expected_msgs.push_back(model_msg);
      end
    end

    // Random streams. Every byte sent counts toward the total.
    while (live_bytes < RandBytes) begin
      b = random_midi_byte();
      send_midi_byte(b, accepted);
      model_got = parse_midi_byte(b, model_msg);
      if (model_got) expected_msgs.push_back(model_msg);
      live_bytes++;
    end
    rx_if.valid <= 1'b0;

    // Drain, then allow for the two-stage pipeline.
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS midi_running_status_parser");
    end else begin
      $display("FAIL midi_running_status_parser");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/mrsp_pkg.sv
src/mrsp_in_if.sv
src/mrsp_out_if.sv
src/midi_running_status_parser.sv
test/midi_running_status_parser_tb.sv
